FILE: rtl/additive_lagged_fibonacci_rng_defines.svh
// Assertion macros used by the checker file of the additive lagged Fibonacci generator.
`ifndef ADDITIVE_LAGGED_FIBONACCI_RNG_DEFINES_SVH
`define ADDITIVE_LAGGED_FIBONACCI_RNG_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ALFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ALFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/alfr_pkg.sv
// Package with shared constants of the additive lagged Fibonacci generator.
package alfr_pkg;

  localparam int unsigned RingDepthDef   = 31;
  localparam int unsigned FeedbackLagDef = 3;
  localparam int unsigned ThrowawayCount = 344;

  localparam logic [14:0] LcgMult  = 15'd16807;
  localparam logic [31:0] LcgMod   = 32'h7FFF_FFFF;
  localparam int unsigned LcgProdW = 47;

  localparam int unsigned DivW     = 32;
  localparam int unsigned DivSteps = DivW / 2;

  localparam logic OpReseed = 1'b0;
  localparam logic OpDraw   = 1'b1;

endpackage

FILE: rtl/alfr_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module alfr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/alfr_div.sv
// Iterative restoring divider that retires two quotient bits per cycle.
module alfr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [alfr_pkg::DivW-1:0] dividend_i,
  input  logic [alfr_pkg::DivW-1:0] divisor_i,
  output logic                      done_o,
  output logic [alfr_pkg::DivW-1:0] quotient_o
);
  import alfr_pkg::*;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] num_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] den_q;

  logic [DivW:0]   r1;
  logic [DivW:0]   r1s;
  logic [DivW:0]   r2;
  logic [DivW:0]   r2s;
  logic            ge1;
  logic            ge2;

  always_comb begin
    r1  = {rem_q, num_q[DivW-1]};
    ge1 = r1 >= {1'b0, den_q};
    r1s = ge1 ? r1 - {1'b0, den_q} : r1;
    r2  = {r1s[DivW-1:0], num_q[DivW-2]};
    ge2 = r2 >= {1'b0, den_q};
    r2s = ge2 ? r2 - {1'b0, den_q} : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= dividend_i;
        den_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        num_q <= {num_q[DivW-3:0], ge1, ge2};
        rem_q <= r2s[DivW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

FILE: rtl/additive_lagged_fibonacci_rng.sv
// Top level of the additive lagged Fibonacci generator with range scaling.
//
//   Channel  Signals                                      Direction
//   in       in_valid_i, in_stall_o, op_i, seed_i,        request into the block
//            range_max_i
//   out      out_valid_o, out_stall_i, raw_value_o,       request out of the block
//            scaled_value_o, range_error_o
//
// One request is worked on at a time; the ring sits in a two-read-port RAM.
// A draw reads the ring, writes the new sum back, then runs two passes of the divider.
// A reseed fills the ring from the seed with the LCG, then runs 344-FeedbackLag
// feedback steps; each step reads the RAM in StFbRd and writes it in StFbWr.
// A zero-range draw skips the ring and divider. Reset leaves the ring reading zero.
// A finished result waits in the output register while out_stall_i is high.
module additive_lagged_fibonacci_rng #(
  parameter int unsigned RingDepth   = alfr_pkg::RingDepthDef,
  parameter int unsigned FeedbackLag = alfr_pkg::FeedbackLagDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] seed_i,
  input  logic [30:0] range_max_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] raw_value_o,
  output logic [30:0] scaled_value_o,
  output logic        range_error_o
);
  import alfr_pkg::*;

  localparam int unsigned AddrW   = $clog2(RingDepth);
  localparam int unsigned LagMod  = FeedbackLag % RingDepth;
  localparam int unsigned FbSteps = ThrowawayCount - FeedbackLag;
  localparam int unsigned StepW   = $clog2(FbSteps);

  localparam logic [AddrW-1:0] LagModA   = AddrW'(LagMod);
  localparam logic [AddrW-1:0] BackA     = AddrW'(RingDepth - LagMod);
  localparam logic [AddrW-1:0] LastA     = AddrW'(RingDepth - 1);
  localparam logic [AddrW-1:0] ThrowModA = AddrW'(ThrowawayCount % RingDepth);
  localparam logic [StepW-1:0] LastStep  = StepW'(FbSteps - 1);
  localparam logic [DivW-1:0]  DivTop    = {1'b1, {(DivW-1){1'b0}}};

  typedef enum logic [3:0] {
    StIdle,
    StLcgMul,
    StLcgRed,
    StFbRd,
    StFbWr,
    StDrRd,
    StDrWr,
    StDiv1,
    StDiv2,
    StDone
  } state_e;

  function automatic logic [AddrW-1:0] behind(input logic [AddrW-1:0] s);
    return (s >= LagModA) ? s - LagModA : s + BackA;
  endfunction

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] s);
    return (s == LastA) ? '0 : s + 1'b1;
  endfunction

  state_e                 state_q;
  logic [AddrW-1:0]       idx_q;
  logic [AddrW-1:0]       ptr_q;
  logic [StepW-1:0]       step_q;
  logic [31:0]            prev_q;
  logic [LcgProdW-1:0]    prod_q;
  logic                   neg_q;
  logic [30:0]            range_q;
  logic [30:0]            raw_q;
  logic [30:0]            scaled_q;
  logic                   err_q;
  logic [RingDepth-1:0]   vld_q;
  logic                   rva_q;
  logic                   rvb_q;
  logic                   out_valid_q;
  logic [30:0]            raw_value_q;
  logic [30:0]            scaled_value_q;
  logic                   range_error_q;

  logic                   in_acc;
  logic                   out_free;
  logic [31:0]            mag;
  logic [31:0]            red_sum;
  logic [31:0]            red;
  logic [30:0]            lcg_v;
  logic [31:0]            rd_a;
  logic [31:0]            rd_b;
  logic [31:0]            ram_a;
  logic [31:0]            ram_b;
  logic                   we;
  logic [AddrW-1:0]       waddr;
  logic [31:0]            wdata;
  logic [AddrW-1:0]       raddr_a;
  logic                   div_start;
  logic [DivW-1:0]        div_dividend;
  logic [DivW-1:0]        div_divisor;
  logic                   div_done;
  logic [DivW-1:0]        div_quo;
  logic [30:0]            clamped;

  assign in_acc   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    mag     = prev_q[31] ? (~prev_q + 32'd1) : prev_q;
    red_sum = {1'b0, prod_q[30:0]} + 32'(prod_q[LcgProdW-1:31]);
    red     = (red_sum >= LcgMod) ? red_sum - LcgMod : red_sum;
    lcg_v   = (neg_q && (red[30:0] != '0)) ? LcgMod[30:0] - red[30:0] : red[30:0];
  end

  assign rd_a    = rva_q ? ram_a : '0;
  assign rd_b    = rvb_q ? ram_b : '0;
  assign raddr_a = (state_q == StDrRd) ? ptr_q : idx_q;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd_a + rd_b;
    unique case (state_q)
      StIdle: begin
        we    = in_acc && (op_i == OpReseed);
        waddr = '0;
        wdata = seed_i;
      end
      StLcgRed: begin
        we    = 1'b1;
        wdata = {1'b0, lcg_v};
      end
      StFbWr: begin
        we = 1'b1;
      end
      StDrWr: begin
        we    = 1'b1;
        waddr = ptr_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  alfr_ram #(
    .Width(32),
    .Depth(RingDepth)
  ) u_ring (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .rdata_a_o(ram_a),
    .raddr_b_i(behind(raddr_a)),
    .rdata_b_o(ram_b)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DivTop;
    div_divisor  = {1'b0, range_q};
    if (state_q == StDrWr) begin
      div_start = 1'b1;
    end else if (state_q == StDiv1 && div_done) begin
      div_start    = 1'b1;
      div_dividend = {1'b0, raw_q};
      div_divisor  = div_quo;
    end
  end

  alfr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign clamped = (div_quo >= {1'b0, range_q}) ? range_q - 31'd1 : div_quo[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      ptr_q       <= '0;
      step_q      <= '0;
      vld_q       <= '0;
      rva_q       <= 1'b0;
      rvb_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rva_q <= vld_q[raddr_a];
      rvb_q <= vld_q[behind(raddr_a)];
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            raw_q    <= '0;
            scaled_q <= '0;
            err_q    <= 1'b0;
            range_q  <= range_max_i;
            if (op_i == OpReseed) begin
              prev_q  <= seed_i;
              idx_q   <= AddrW'(1);
              state_q <= StLcgMul;
            end else if (range_max_i == '0) begin
              err_q   <= 1'b1;
              state_q <= StDone;
            end else begin
              state_q <= StDrRd;
            end
          end
        end
        StLcgMul: begin
          prod_q  <= LcgProdW'(mag) * LcgProdW'(LcgMult);
          neg_q   <= prev_q[31];
          state_q <= StLcgRed;
        end
        StLcgRed: begin
          prev_q <= {1'b0, lcg_v};
          if (idx_q == LastA) begin
            idx_q   <= LagModA;
            step_q  <= '0;
            state_q <= StFbRd;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= StLcgMul;
          end
        end
        StFbRd: begin
          state_q <= StFbWr;
        end
        StFbWr: begin
          idx_q  <= wrap_inc(idx_q);
          step_q <= step_q + 1'b1;
          if (step_q == LastStep) begin
            ptr_q   <= ThrowModA;
            state_q <= StDone;
          end else begin
            state_q <= StFbRd;
          end
        end
        StDrRd: begin
          state_q <= StDrWr;
        end
        StDrWr: begin
          raw_q   <= rd_a[31:1];
          ptr_q   <= wrap_inc(ptr_q);
          state_q <= StDiv1;
        end
        StDiv1: begin
          if (div_done) begin
            state_q <= StDiv2;
          end
        end
        StDiv2: begin
          if (div_done) begin
            scaled_q <= clamped;
            state_q  <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            raw_value_q    <= raw_q;
            scaled_value_q <= scaled_q;
            range_error_q  <= err_q;
            state_q        <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o     = (state_q != StIdle);
  assign out_valid_o    = out_valid_q;
  assign raw_value_o    = raw_value_q;
  assign scaled_value_o = scaled_value_q;
  assign range_error_o  = range_error_q;

endmodule

FILE: rtl/alfr_checker.sv
// Port-level checker for the additive lagged Fibonacci generator, with its bind.
`include "additive_lagged_fibonacci_rng_defines.svh"

module alfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [30:0] raw_value_o,
  input logic [30:0] scaled_value_o,
  input logic        range_error_o
);

  `ALFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `ALFR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ALFR_ASSERT_NOW(a_err_zero, out_valid_o && range_error_o, (raw_value_o == '0) && (scaled_value_o == '0))
  `ALFR_ASSERT_NOW(a_scaled_le_raw, out_valid_o, scaled_value_o <= raw_value_o)

endmodule

bind additive_lagged_fibonacci_rng alfr_checker u_alfr_checker (.*);

FILE: verif/tb_additive_lagged_fibonacci_rng.sv
// Self-checking testbench for the additive lagged Fibonacci generator with range scaling.
module tb_additive_lagged_fibonacci_rng;

  localparam logic OP_RESEED = alfr_pkg::OpReseed;
  localparam logic OP_DRAW   = alfr_pkg::OpDraw;

  localparam int unsigned RING_LEN      = alfr_pkg::RingDepthDef;
  localparam int unsigned LAG           = alfr_pkg::FeedbackLagDef;
  localparam int unsigned RANDOM_ITEMS  = 1400;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LONG_HOLD     = 500;
  localparam int unsigned HOLD_AT       = 300;

  typedef struct {
    logic [30:0] raw;
    logic [30:0] scaled;
    logic        err;
  } rng_result_t;

  class rng_scoreboard;
    logic [31:0] ring [RING_LEN];
    int unsigned head;
    rng_result_t expected_q [$];
    int unsigned error_count;
    int unsigned result_count;

    function new();
      foreach (ring[k]) ring[k] = '0;
      head = 0;
      error_count = 0;
      result_count = 0;
    endfunction

    function int unsigned lag_slot(int unsigned pos);
      return (pos + RING_LEN - (LAG % RING_LEN)) % RING_LEN;
    endfunction

    function void load_seed(logic [31:0] seed);
      longint prev;
      longint v;
      longint mult;
      longint modulus;
      int unsigned k;
      int unsigned s;
      mult = alfr_pkg::LcgMult;
      modulus = alfr_pkg::LcgMod;
      ring[0] = seed;
      prev = $signed(seed);
      for (k = 1; k < RING_LEN; k++) begin
        v = (prev * mult) % modulus;
        if (v < 0) v += modulus;
        ring[k] = v[31:0];
        prev = v;
      end
      for (k = RING_LEN + LAG; k < alfr_pkg::ThrowawayCount + RING_LEN; k++) begin
        s = k % RING_LEN;
        ring[s] += ring[lag_slot(s)];
      end
      head = alfr_pkg::ThrowawayCount % RING_LEN;
    endfunction

    function void note_request(logic op, logic [31:0] seed, logic [30:0] rmax);
      rng_result_t want;
      logic [31:0] divisor;
      logic [31:0] quotient;
      want = '{raw: '0, scaled: '0, err: 1'b0};
      if (op == OP_RESEED) begin
        load_seed(seed);
      end else if (rmax == '0) begin
        want.err = 1'b1;
      end else begin
        want.raw = ring[head][31:1];
        ring[head] += ring[lag_slot(head)];
        head = (head + 1) % RING_LEN;
        divisor = 32'h8000_0000 / {1'b0, rmax};
        quotient = {1'b0, want.raw} / divisor;
        if (quotient >= {1'b0, rmax}) quotient = {1'b0, rmax} - 32'd1;
        want.scaled = quotient[30:0];
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(logic [30:0] raw, logic [30:0] scaled, logic err);
      rng_result_t want;
      result_count++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result raw_value %h scaled_value %h range_error %b",
                 $time, raw, scaled, err);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (raw !== want.raw) begin
        $display("%0t: raw_value expected %h, got %h", $time, want.raw, raw);
        error_count++;
      end
      if (scaled !== want.scaled) begin
        $display("%0t: scaled_value expected %h, got %h", $time, want.scaled, scaled);
        error_count++;
      end
      if (err !== want.err) begin
        $display("%0t: range_error expected %b, got %b", $time, want.err, err);
        error_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OP_DRAW;
  logic [31:0] seed_i = '0;
  logic [30:0] range_max_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [30:0] raw_value_o;
  logic [30:0] scaled_value_o;
  logic        range_error_o;

  rng_scoreboard sb = new();
  int unsigned cycle_count = 0;

  additive_lagged_fibonacci_rng dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .seed_i         (seed_i),
    .range_max_i    (range_max_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .raw_value_o    (raw_value_o),
    .scaled_value_o (scaled_value_o),
    .range_error_o  (range_error_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(raw_value_o, scaled_value_o, range_error_o);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(100, 30);
  endfunction

  function automatic logic [30:0] pick_range();
    int unsigned r;
    logic [30:0] v;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 20) return 31'($urandom_range(16, 1));
    if (r < 30) begin
      v = 31'd1 << $urandom_range(30);
      case ($urandom_range(2))
        0: return v;
        1: return v + 31'd1;
        default: return v - 31'd1;
      endcase
    end
    if (r < 40) return 31'h7FFF_FFFF - 31'($urandom_range(15));
    if (r < 45) return 31'h4000_0000 + 31'($urandom_range(1));
    return 31'($urandom);
  endfunction

  function automatic logic [31:0] pick_seed();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return 32'($urandom_range(100, 1));
    if (r < 30) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        default: return 32'h7FFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  // The previous request is withdrawn before any pause so it is never taken twice.
  task automatic send_request(logic op, logic [31:0] seed, logic [30:0] rmax,
                              int unsigned gap, bit drain);
    @(negedge clk_i);
    if (gap != 0 || drain) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      if (gap > 1) repeat (gap - 1) @(negedge clk_i);
      while (drain && sb.pending() != 0) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    seed_i <= seed;
    range_max_i <= rmax;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(op, seed, rmax);
  endtask

  initial begin
    int unsigned hold_left;
    bit long_done;
    int unsigned r;
    hold_left = 0;
    long_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_done && sb.result_count >= HOLD_AT) begin
        long_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
        r = $urandom_range(99);
        if (((sb.result_count / 200) % 3) != 1) begin
          if (r < 15) hold_left = $urandom_range(3, 1);
          else if (r < 18) hold_left = $urandom_range(80, 20);
        end
      end
    end
  end

  initial begin
    int unsigned n;
    logic op;
    logic [31:0] seed;
    logic [30:0] rmax;
    bit calm;
    bit drain;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Draws before any reseed see an all-zero ring.
    send_request(OP_DRAW, $urandom, 31'd1, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'd0, pick_gap(), 1'b0);
    send_request(OP_RESEED, 32'h0000_0000, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_DRAW, 32'hFFFF_FFFF, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_RESEED, 32'h0000_0001, 31'd0, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'd1, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'd2, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'd0, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h4000_0000, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h4000_0001, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'd3, pick_gap(), 1'b0);
    send_request(OP_RESEED, 32'hFFFF_FFFF, 31'd5, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h5555_5555, pick_gap(), 1'b0);
    send_request(OP_RESEED, 32'h8000_0000, 31'h2AAA_AAAA, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h2AAA_AAAA, pick_gap(), 1'b0);
    send_request(OP_RESEED, 32'h7FFF_FFFF, 31'd1, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_RESEED, 32'd12345, 31'h7FFF_FFFF, pick_gap(), 1'b0);
    send_request(OP_DRAW, $urandom, 31'd7, pick_gap(), 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 150) % 4) == 2;
      if ($urandom_range(99) < 3) begin
        op = OP_RESEED;
        seed = pick_seed();
        rmax = 31'($urandom);
      end else begin
        op = OP_DRAW;
        seed = $urandom;
        rmax = pick_range();
      end
      drain = (n == RANDOM_ITEMS / 2) || ($urandom_range(199) == 0);
      send_request(op, seed, rmax, calm ? 0 : pick_gap(), drain);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/alfr_pkg.sv
rtl/alfr_ram.sv
rtl/alfr_div.sv
rtl/additive_lagged_fibonacci_rng.sv
rtl/alfr_checker.sv
verif/tb_additive_lagged_fibonacci_rng.sv
